// ----- rtl/h264fua_pkg.sv -----
// ----------------------------------------------------------------------------
// h264fua_pkg
// Shared types and constants of the H.264 RTP FU-A packetizer.
// ----------------------------------------------------------------------------
package h264fua_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_PLAYING    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SSRC       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TS_STEP    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_START_SEQ  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_START_TS   = 3'd4;

  localparam logic [31:0] SSRC_RESET    = 32'd4096;
  localparam logic [31:0] TS_STEP_RESET = 32'd3600;

  localparam logic [7:0] INTERLEAVE_MAGIC = 8'h24;
  localparam logic [7:0] INTERLEAVE_CHAN  = 8'h00;
  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [6:0] RTP_PAYLOAD_TYPE = 7'd96;
  localparam logic [4:0] FU_A_TYPE        = 5'd28;
  localparam logic [4:0] NAL_TYPE_SLICE   = 5'd1;
  localparam logic [4:0] NAL_TYPE_IDR     = 5'd5;
  localparam logic [15:0] RTP_HDR_LEN     = 16'd12;
  localparam logic [15:0] FU_HDR_LEN      = 16'd14;

  // Back-end byte sequencer steps: 0..15 interleave and RTP header.
  localparam int unsigned StepW = 5;
  localparam logic [StepW-1:0] STEP_HDR_FIRST = 5'd0;
  localparam logic [StepW-1:0] STEP_HDR_LAST  = 5'd15;
  localparam logic [StepW-1:0] STEP_FU_IND    = 5'd16;
  localparam logic [StepW-1:0] STEP_FU_HDR    = 5'd17;
  localparam logic [StepW-1:0] STEP_PAYLOAD   = 5'd18;
  localparam logic [StepW-1:0] STEP_START     = 5'd31;

  typedef struct packed {
    logic [7:0]  payload;
    logic        pend;
    logic        has_hdr;
    logic        has_fu;
    logic        mark;
    logic [15:0] pkt_len;
    logic [15:0] pkt_cnt;
    logic [31:0] ts_acc;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
  } job_t;

  typedef struct packed {
    logic [31:0] ssrc;
    logic [15:0] start_seq;
    logic [31:0] start_ts;
  } hdr_cfg_t;

endpackage

// ----- rtl/h264fua_front.sv -----
// ----------------------------------------------------------------------------
// h264fua_front
// Accepts NAL bytes, tracks NAL and fragment position, and builds one job
// per byte that produces output.
// ----------------------------------------------------------------------------
module h264fua_front #(
  parameter int unsigned MAX_PAYLOAD_BYTES = 1400
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                playing_i,
  input  logic [31:0]         ts_step_i,
  input  logic                nal_valid_i,
  output logic                nal_ready_o,
  input  logic [7:0]          nal_byte_i,
  input  logic [23:0]         nal_length_i,
  output logic                push_o,
  output h264fua_pkg::job_t   job_o,
  input  logic                full_i
);

  localparam logic [23:0] MaxLen = 24'(MAX_PAYLOAD_BYTES);

  logic [23:0] offset_q, offset_d;
  logic [15:0] pkt_cnt_q, pkt_cnt_d;
  logic [31:0] ts_acc_q, ts_acc_d;
  logic [7:0]  fu_ind_q, fu_ind_d;
  logic [4:0]  type_q, type_d;
  logic [10:0] chunk_left_q, chunk_left_d;
  logic        single_q, single_d;

  logic        acc;
  logic        live;
  logic [23:0] pos;
  logic [23:0] remain;
  logic        nal_end;
  logic        nal_start;
  logic [10:0] chunk_base;
  logic [10:0] chunk;
  logic        frag_last;
  logic        new_chunk;
  logic [10:0] cl;
  logic        emit;

  assign nal_ready_o = !full_i;
  assign acc  = nal_valid_i && nal_ready_o;
  assign live = playing_i && (nal_length_i != '0);

  always_comb begin
    pos       = (offset_q >= nal_length_i) ? '0 : offset_q;
    remain    = nal_length_i - pos;
    nal_end   = (remain == 24'd1);
    nal_start = (pos == '0);

    type_d       = nal_start ? nal_byte_i[4:0] : type_q;
    fu_ind_d     = nal_start ? {nal_byte_i[7:5], h264fua_pkg::FU_A_TYPE} : fu_ind_q;
    single_d     = nal_start ? (nal_length_i <= MaxLen) : single_q;
    chunk_base   = nal_start ? '0 : chunk_left_q;
    ts_acc_d     = ts_acc_q;
    if (nal_start && (type_d == h264fua_pkg::NAL_TYPE_SLICE ||
                      type_d == h264fua_pkg::NAL_TYPE_IDR)) begin
      ts_acc_d = ts_acc_q + ts_step_i;
    end

    chunk     = (remain > MaxLen) ? MaxLen[10:0] : remain[10:0];
    frag_last = (remain <= MaxLen);
    new_chunk = (chunk_base == '0);
    cl        = (new_chunk ? chunk : chunk_base) - 11'd1;
    if (nal_end) begin
      cl = '0;
    end

    job_o         = '0;
    job_o.payload = nal_byte_i;
    job_o.pkt_cnt = pkt_cnt_q;
    job_o.ts_acc  = ts_acc_d;
    job_o.fu_ind  = fu_ind_d;
    emit          = 1'b0;
    chunk_left_d  = chunk_base;
    if (single_d) begin
      emit          = 1'b1;
      job_o.has_hdr = nal_start;
      job_o.mark    = 1'b1;
      job_o.pkt_len = h264fua_pkg::RTP_HDR_LEN + nal_length_i[15:0];
      job_o.pend    = nal_end;
    end else if (!nal_start) begin
      emit          = 1'b1;
      job_o.has_hdr = new_chunk;
      job_o.has_fu  = new_chunk;
      job_o.mark    = frag_last;
      job_o.pkt_len = h264fua_pkg::FU_HDR_LEN + 16'(chunk);
      job_o.fu_hdr  = {pos == 24'd1, frag_last, 1'b0, type_d};
      job_o.pend    = (cl == '0);
      chunk_left_d  = cl;
    end

    pkt_cnt_d = job_o.has_hdr ? pkt_cnt_q + 16'd1 : pkt_cnt_q;
    offset_d  = nal_end ? '0 : pos + 24'd1;
  end

  assign push_o = acc && live && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q     <= '0;
      pkt_cnt_q    <= '0;
      ts_acc_q     <= '0;
      fu_ind_q     <= '0;
      type_q       <= '0;
      chunk_left_q <= '0;
      single_q     <= 1'b0;
    end else if (acc && live) begin
      offset_q     <= offset_d;
      pkt_cnt_q    <= pkt_cnt_d;
      ts_acc_q     <= ts_acc_d;
      fu_ind_q     <= fu_ind_d;
      type_q       <= type_d;
      chunk_left_q <= chunk_left_d;
      single_q     <= single_d;
    end
  end

endmodule

// ----- rtl/h264fua_queue.sv -----
// ----------------------------------------------------------------------------
// h264fua_queue
// Two-entry job queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module h264fua_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  h264fua_pkg::job_t  push_job_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               head_valid_o,
  output h264fua_pkg::job_t  head_job_o
);

  h264fua_pkg::job_t mem_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] count_q;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_job_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- rtl/h264fua_back.sv -----
// ----------------------------------------------------------------------------
// h264fua_back
// Byte sequencer: expands each job into interleave header, RTP header,
// FU-A bytes and payload byte, through a registered output stage.
// ----------------------------------------------------------------------------
module h264fua_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  h264fua_pkg::hdr_cfg_t   cfg_i,
  input  logic                    head_valid_i,
  input  h264fua_pkg::job_t       head_job_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [7:0]              out_byte_o,
  output logic                    packet_end_o,
  output logic                    run_last_o
);

  logic [h264fua_pkg::StepW-1:0] step_q, step_d, step;
  logic        out_valid_q;
  logic [7:0]  byte_q, byte_d;
  logic        pend_q, last_q, is_last;
  logic        advance;
  logic [15:0] seq;
  logic [31:0] ts;

  assign advance = head_valid_i && (!out_valid_q || out_ready_i);
  assign seq     = cfg_i.start_seq + head_job_i.pkt_cnt;
  assign ts      = cfg_i.start_ts + head_job_i.ts_acc;

  always_comb begin
    step = step_q;
    if (step_q == h264fua_pkg::STEP_START) begin
      step = head_job_i.has_hdr ? h264fua_pkg::STEP_HDR_FIRST : h264fua_pkg::STEP_PAYLOAD;
    end
    is_last = (step == h264fua_pkg::STEP_PAYLOAD);
    if (is_last) begin
      step_d = h264fua_pkg::STEP_START;
    end else if (step == h264fua_pkg::STEP_HDR_LAST) begin
      step_d = head_job_i.has_fu ? h264fua_pkg::STEP_FU_IND : h264fua_pkg::STEP_PAYLOAD;
    end else begin
      step_d = step + 5'd1;
    end
  end

  always_comb begin
    case (step)
      5'd0:    byte_d = h264fua_pkg::INTERLEAVE_MAGIC;
      5'd1:    byte_d = h264fua_pkg::INTERLEAVE_CHAN;
      5'd2:    byte_d = head_job_i.pkt_len[15:8];
      5'd3:    byte_d = head_job_i.pkt_len[7:0];
      5'd4:    byte_d = h264fua_pkg::RTP_VERSION_BYTE;
      5'd5:    byte_d = {head_job_i.mark, h264fua_pkg::RTP_PAYLOAD_TYPE};
      5'd6:    byte_d = seq[15:8];
      5'd7:    byte_d = seq[7:0];
      5'd8:    byte_d = ts[31:24];
      5'd9:    byte_d = ts[23:16];
      5'd10:   byte_d = ts[15:8];
      5'd11:   byte_d = ts[7:0];
      5'd12:   byte_d = cfg_i.ssrc[31:24];
      5'd13:   byte_d = cfg_i.ssrc[23:16];
      5'd14:   byte_d = cfg_i.ssrc[15:8];
      5'd15:   byte_d = cfg_i.ssrc[7:0];
      h264fua_pkg::STEP_FU_IND: byte_d = head_job_i.fu_ind;
      h264fua_pkg::STEP_FU_HDR: byte_d = head_job_i.fu_hdr;
      default: byte_d = head_job_i.payload;
    endcase
  end

  assign pop_o = advance && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= h264fua_pkg::STEP_START;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        step_q      <= step_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q <= byte_d;
      pend_q <= is_last && head_job_i.pend;
      last_q <= is_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign packet_end_o = pend_q;
  assign run_last_o   = last_q;

endmodule

// ----- rtl/h264_rtp_fua_packetizer.sv -----
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer
// H.264 RTP packetizer (single NAL and FU-A) with TCP-interleaved framing.
// ----------------------------------------------------------------------------
// Takes one NAL byte per transaction and emits the framed stream one byte per
// transaction. A payload byte yields one output byte; the first byte of a
// NAL sent whole adds 16 header bytes and the first byte of each FU-A
// fragment adds 18, all paced by the back-end byte sequencer; the header
// byte of a fragmented NAL and a dropped byte produce no output. A two-entry
// job queue lets the front end take the next byte while the sequencer is
// still busy.
module h264_rtp_fua_packetizer #(
  parameter int unsigned MAX_PAYLOAD_BYTES = 1400
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        nal_valid_i,
  output logic        nal_ready_o,
  input  logic [7:0]  nal_byte_i,
  input  logic [23:0] nal_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        packet_end_o,
  output logic        run_last_o
);

  logic        playing_q;
  logic [31:0] ts_step_q;
  h264fua_pkg::hdr_cfg_t hdr_cfg_q;

  logic              push;
  logic              full;
  logic              pop;
  logic              head_valid;
  h264fua_pkg::job_t push_job;
  h264fua_pkg::job_t head_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q           <= 1'b0;
      ts_step_q           <= h264fua_pkg::TS_STEP_RESET;
      hdr_cfg_q.ssrc      <= h264fua_pkg::SSRC_RESET;
      hdr_cfg_q.start_seq <= '0;
      hdr_cfg_q.start_ts  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        h264fua_pkg::CFG_PLAYING:    playing_q           <= cfg_wdata_i[0];
        h264fua_pkg::CFG_SSRC:       hdr_cfg_q.ssrc      <= cfg_wdata_i;
        h264fua_pkg::CFG_TS_STEP:    ts_step_q           <= cfg_wdata_i;
        h264fua_pkg::CFG_START_SEQ:  hdr_cfg_q.start_seq <= cfg_wdata_i[15:0];
        h264fua_pkg::CFG_START_TS:   hdr_cfg_q.start_ts  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  h264fua_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .playing_i    (playing_q),
    .ts_step_i    (ts_step_q),
    .nal_valid_i  (nal_valid_i),
    .nal_ready_o  (nal_ready_o),
    .nal_byte_i   (nal_byte_i),
    .nal_length_i (nal_length_i),
    .push_o       (push),
    .job_o        (push_job),
    .full_i       (full)
  );

  h264fua_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  h264fua_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (hdr_cfg_q),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .packet_end_o (packet_end_o),
    .run_last_o   (run_last_o)
  );

endmodule

// ----- verif/h264_rtp_fua_packetizer_checker.sv -----
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer_checker
// Predicts the framed RTP byte stream from the accepted NAL bytes and checks
// every output transaction against it, field by field, in order.
// ----------------------------------------------------------------------------
module h264_rtp_fua_packetizer_checker #(
  parameter int unsigned MAX_PAYLOAD_BYTES = 1400
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        nal_valid_i,
  input  logic        nal_ready_i,
  input  logic [7:0]  nal_byte_i,
  input  logic [23:0] nal_length_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        packet_end_i,
  input  logic        run_last_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       pend;
    logic       last;
  } stream_byte_t;

  stream_byte_t due_q[$];
  stream_byte_t held;
  logic         have_held;

  logic        playing;
  logic [31:0] ssrc;
  logic [31:0] ts_step;
  logic [15:0] start_seq;
  logic [31:0] start_ts;

  logic [23:0] byte_offset;
  logic [15:0] packet_count;
  logic [31:0] ts_accum;
  logic [7:0]  fu_indicator;
  logic [4:0]  nal_type;
  logic [10:0] chunk_left;
  logic        single_mode;

  int fail_count = 0;
  int pending    = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  task automatic queue_byte(input logic [7:0] b, input logic pend);
    if (have_held) due_q.push_back(held);
    held      = '{data: b, pend: pend, last: 1'b0};
    have_held = 1'b1;
  endtask

  task automatic queue_rtp_header(input logic [15:0] pkt_len, input logic mark);
    logic [15:0] seq;
    logic [31:0] ts;
    seq = start_seq + packet_count;
    ts  = start_ts + ts_accum;
    queue_byte(h264fua_pkg::INTERLEAVE_MAGIC, 1'b0);
    queue_byte(h264fua_pkg::INTERLEAVE_CHAN, 1'b0);
    queue_byte(pkt_len[15:8], 1'b0);
    queue_byte(pkt_len[7:0], 1'b0);
    queue_byte(h264fua_pkg::RTP_VERSION_BYTE, 1'b0);
    queue_byte({mark, h264fua_pkg::RTP_PAYLOAD_TYPE}, 1'b0);
    queue_byte(seq[15:8], 1'b0);
    queue_byte(seq[7:0], 1'b0);
    queue_byte(ts[31:24], 1'b0);
    queue_byte(ts[23:16], 1'b0);
    queue_byte(ts[15:8], 1'b0);
    queue_byte(ts[7:0], 1'b0);
    queue_byte(ssrc[31:24], 1'b0);
    queue_byte(ssrc[23:16], 1'b0);
    queue_byte(ssrc[15:8], 1'b0);
    queue_byte(ssrc[7:0], 1'b0);
    packet_count = packet_count + 16'd1;
  endtask

  task automatic packetize_byte(input logic [7:0] b, input logic [23:0] len);
    logic [23:0] pos;
    logic        nal_end;
    logic [23:0] chunk;
    logic        last_frag;
    have_held = 1'b0;
    if (!playing || len == 24'd0) return;
    if (byte_offset >= len) byte_offset = 24'd0;
    pos     = byte_offset;
    nal_end = ({1'b0, pos} + 25'd1 >= {1'b0, len});
    if (pos == 24'd0) begin
      nal_type     = b[4:0];
      fu_indicator = {b[7:5], h264fua_pkg::FU_A_TYPE};
      single_mode  = (len <= 24'(MAX_PAYLOAD_BYTES));
      chunk_left   = 11'd0;
      if (nal_type == h264fua_pkg::NAL_TYPE_SLICE ||
          nal_type == h264fua_pkg::NAL_TYPE_IDR) begin
        ts_accum = ts_accum + ts_step;
      end
    end
    if (single_mode) begin
      if (pos == 24'd0) queue_rtp_header(h264fua_pkg::RTP_HDR_LEN + len[15:0], 1'b1);
      queue_byte(b, nal_end);
    end else if (pos != 24'd0) begin
      if (chunk_left == 11'd0) begin
        chunk = len - pos;
        if (chunk > 24'(MAX_PAYLOAD_BYTES)) chunk = 24'(MAX_PAYLOAD_BYTES);
        last_frag = ({1'b0, pos} + {1'b0, chunk} >= {1'b0, len});
        queue_rtp_header(h264fua_pkg::FU_HDR_LEN + chunk[15:0], last_frag);
        queue_byte(fu_indicator, 1'b0);
        queue_byte({pos == 24'd1, last_frag, 1'b0, nal_type}, 1'b0);
        chunk_left = chunk[10:0];
      end
      chunk_left = chunk_left - 11'd1;
      if (nal_end) chunk_left = 11'd0;
      queue_byte(b, chunk_left == 11'd0);
    end
    byte_offset = nal_end ? 24'd0 : pos + 24'd1;
    if (have_held) begin
      held.last = 1'b1;
      due_q.push_back(held);
    end
  endtask

  task automatic check_output();
    stream_byte_t exp_b;
    if (due_q.size() == 0) begin
      $error("unexpected output transaction: out_byte %02h", out_byte_i);
      fail_count++;
      return;
    end
    exp_b = due_q.pop_front();
    if (out_byte_i !== exp_b.data) begin
      $error("out_byte: expected %02h, got %02h", exp_b.data, out_byte_i);
      fail_count++;
    end
    if (packet_end_i !== exp_b.pend) begin
      $error("packet_end: expected %0b, got %0b", exp_b.pend, packet_end_i);
      fail_count++;
    end
    if (run_last_i !== exp_b.last) begin
      $error("run_last: expected %0b, got %0b", exp_b.last, run_last_i);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing      = 1'b0;
      ssrc         = h264fua_pkg::SSRC_RESET;
      ts_step      = h264fua_pkg::TS_STEP_RESET;
      start_seq    = 16'd0;
      start_ts     = 32'd0;
      byte_offset  = 24'd0;
      packet_count = 16'd0;
      ts_accum     = 32'd0;
      fu_indicator = 8'd0;
      nal_type     = 5'd0;
      chunk_left   = 11'd0;
      single_mode  = 1'b0;
      have_held    = 1'b0;
      due_q.delete();
      pending      = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_output();
      if (cfg_we_i) begin
        case (cfg_index_i)
          h264fua_pkg::CFG_PLAYING:   playing   = cfg_wdata_i[0];
          h264fua_pkg::CFG_SSRC:      ssrc      = cfg_wdata_i;
          h264fua_pkg::CFG_TS_STEP:   ts_step   = cfg_wdata_i;
          h264fua_pkg::CFG_START_SEQ: start_seq = cfg_wdata_i[15:0];
          h264fua_pkg::CFG_START_TS:  start_ts  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (nal_valid_i && nal_ready_i) packetize_byte(nal_byte_i, nal_length_i);
      pending = due_q.size();
    end
  end

endmodule

// ----- verif/h264_rtp_fua_packetizer_tb.sv -----
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer_tb
// Drives NAL bytes and register writes into the packetizer under random
// backpressure on both sides and reports the verdict of the stream checker.
// ----------------------------------------------------------------------------
module h264_rtp_fua_packetizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPayload  = 1400;
  localparam int          HoldCycles  = 400;
  localparam int          SettleWait  = 64;
  localparam int          PhaseItems  = 120;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        nal_valid;
  logic        nal_ready;
  logic [7:0]  nal_byte;
  logic [23:0] nal_length;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        packet_end;
  logic        run_last;

  int fail_count;
  int pending;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req     = 0;
  int hold_ack     = 0;
  int hold_left    = 0;
  int items_sent   = 0;

  h264_rtp_fua_packetizer #(
    .MAX_PAYLOAD_BYTES(MaxPayload)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .nal_valid_i  (nal_valid),
    .nal_ready_o  (nal_ready),
    .nal_byte_i   (nal_byte),
    .nal_length_i (nal_length),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_o   (out_byte),
    .packet_end_o (packet_end),
    .run_last_o   (run_last)
  );

  h264_rtp_fua_packetizer_checker #(
    .MAX_PAYLOAD_BYTES(MaxPayload)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .nal_valid_i  (nal_valid),
    .nal_ready_i  (nal_ready),
    .nal_byte_i   (nal_byte),
    .nal_length_i (nal_length),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_i   (out_byte),
    .packet_end_i (packet_end),
    .run_last_i   (run_last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("** h264_rtp_fua_packetizer: FAILED **");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HoldCycles - 1;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic [23:0] len);
    while ($urandom_range(99) < snd_idle_pct) begin
      nal_valid = 1'b0;
      @(negedge clk);
    end
    nal_valid  = 1'b1;
    nal_byte   = b;
    nal_length = len;
    do @(posedge clk); while (!nal_ready);
    @(negedge clk);
    if (len != 24'd0) items_sent++;
  endtask

  // drain the stream until the checker has no expected bytes pending, then keep the inputs idle
  task automatic settle();
    nal_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleWait) @(negedge clk);
  endtask

  function automatic logic [7:0] nal_head();
    logic [4:0] t;
    case ($urandom_range(3))
      0:       t = h264fua_pkg::NAL_TYPE_SLICE;
      1:       t = h264fua_pkg::NAL_TYPE_IDR;
      default: t = 5'($urandom_range(31));
    endcase
    return {3'($urandom), t};
  endfunction

  task automatic send_nal(input logic [23:0] len, input int count);
    for (int i = 0; i < count; i++) begin
      push_byte((i == 0) ? nal_head() : 8'($urandom), len);
    end
  endtask

  task automatic run_phase(input int target, input logic [23:0] long_len);
    int          start;
    int          r;
    int          len;
    bit          long_done;
    start     = items_sent;
    long_done = 1'b0;
    while (items_sent - start < target) begin
      r = $urandom_range(99);
      if (!long_done && items_sent - start >= target / 2) begin
        send_nal(long_len, $urandom_range(2, 40));
        long_done = 1'b1;
      end else if (r < 82) begin
        len = $urandom_range(1, 24);
        send_nal(24'(len), len);
      end else if (r < 90) begin
        len = $urandom_range(2, 40);
        send_nal(24'(len), $urandom_range(1, len - 1));
      end else if (r < 95) begin
        push_byte(8'($urandom), 24'd0);
      end else begin
        push_byte(8'($urandom), 24'($urandom_range(1, 24'hFF_FFFF)));
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = h264fua_pkg::CFG_PLAYING;
    cfg_wdata  = 32'd0;
    nal_valid  = 1'b0;
    nal_byte   = 8'd0;
    nal_length = 24'd0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    snd_idle_pct = 29;
    rcv_idle_pct = 71;
    push_byte(8'h65, 24'd1);
    push_byte(8'h41, 24'd2);
    settle();

    cfg_write(h264fua_pkg::CFG_PLAYING, 32'd1);
    push_byte(8'h65, 24'd1);
    push_byte(8'h41, 24'd3);
    push_byte(8'hAA, 24'd3);
    push_byte(8'h55, 24'd3);
    push_byte(8'h06, 24'd2);
    push_byte(8'hFF, 24'd2);
    push_byte(8'h00, 24'd0);
    push_byte(8'hFF, 24'hFF_FFFF);
    push_byte(8'h00, 24'hFF_FFFF);
    push_byte(8'h12, 24'hFF_FFFF);
    push_byte(8'h34, 24'hFF_FFFF);
    push_byte(8'h67, 24'd2);
    push_byte(8'h42, 24'd2);
    push_byte(8'h25, 24'd1500);
    push_byte(8'h01, 24'd1500);
    push_byte(8'h02, 24'd1500);
    push_byte(8'h03, 24'd4);
    push_byte(8'hE1, 24'd1);
    settle();

    cfg_write(h264fua_pkg::CFG_SSRC, 32'd0);
    cfg_write(h264fua_pkg::CFG_TS_STEP, 32'd1);
    cfg_write(h264fua_pkg::CFG_START_SEQ, 32'h0000_FFFF);
    cfg_write(h264fua_pkg::CFG_START_TS, 32'hFFFF_FFFF);
    hold_req++;
    run_phase(PhaseItems, 24'd1401);
    settle();

    snd_idle_pct = 71;
    rcv_idle_pct = 29;
    cfg_write(h264fua_pkg::CFG_SSRC, 32'hFFFF_FFFF);
    cfg_write(h264fua_pkg::CFG_TS_STEP, 32'hFFFF_FFFF);
    cfg_write(h264fua_pkg::CFG_START_SEQ, 32'($urandom_range(16'hFFFF)));
    cfg_write(h264fua_pkg::CFG_START_TS, 32'd0);
    run_phase(PhaseItems, 24'd2802);
    settle();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    cfg_write(h264fua_pkg::CFG_PLAYING, 32'd0);
    send_nal(24'd4, 4);
    settle();
    cfg_write(h264fua_pkg::CFG_PLAYING, 32'd1);
    cfg_write(h264fua_pkg::CFG_SSRC, $urandom);
    cfg_write(h264fua_pkg::CFG_TS_STEP, $urandom_range(1, 32'hFFFF_FFFF));
    cfg_write(h264fua_pkg::CFG_START_SEQ, 32'($urandom_range(16'hFFFF)));
    cfg_write(h264fua_pkg::CFG_START_TS, $urandom);
    run_phase(PhaseItems, 24'd1400);
    settle();

    if (fail_count == 0) begin
      $display("** h264_rtp_fua_packetizer: PASSED **");
    end else begin
      $display("** h264_rtp_fua_packetizer: FAILED **");
    end
    $finish;
  end

endmodule
